[hdl/gripper_stall_detect_fsm_defines.svh]
// Assertion helpers for the gripper stall detector.
// Both expect signals named clock and reset in the using scope.
`ifndef GRIPPER_STALL_DETECT_FSM_DEFINES_SVH
`define GRIPPER_STALL_DETECT_FSM_DEFINES_SVH

// same-cycle implication
`define GSD_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define GSD_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[hdl/gsd_pkg.sv]
package gsd_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_OPEN_TARGET   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CLOSED_TARGET = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TOLERANCE     = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACCEL_DELAY   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_CHECK_WINDOW  = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_PROGRESS  = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_FAILURES  = 3'd6;

   typedef enum logic [1:0] {
      OP_TICK  = 2'd0,
      OP_OPEN  = 2'd1,
      OP_CLOSE = 2'd2,
      OP_RESET = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MODE_CLOSED  = 2'd0,
      MODE_OPEN    = 2'd1,
      MODE_OPENING = 2'd2,
      MODE_CLOSING = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      DRV_NONE  = 2'd0,
      DRV_STOP  = 2'd1,
      DRV_OPEN  = 2'd2,
      DRV_CLOSE = 2'd3
   } drive_type;

   typedef struct packed {
      logic [9:0]  open_target;
      logic [9:0]  closed_target;
      logic [9:0]  position_tolerance;
      logic [15:0] accel_delay_ms;
      logic [15:0] check_window_ms;
      logic [9:0]  min_progress;
      logic [7:0]  max_failures;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      open_target:        10'd1023,
      closed_target:      10'd0,
      position_tolerance: 10'd10,
      accel_delay_ms:     16'd200,
      check_window_ms:    16'd500,
      min_progress:       10'd5,
      max_failures:       8'd3
   };

   typedef struct packed {
      mode_type    mode;
      logic [31:0] ref_time;
      logic [9:0]  ref_position;
      logic [7:0]  fail_count;
   } state_type;

   localparam state_type STATE_RESET = '{
      mode:         MODE_CLOSED,
      ref_time:     32'd0,
      ref_position: 10'd0,
      fail_count:   8'd0
   };

   typedef struct packed {
      op_type      op;
      logic [31:0] now_ms;
      logic [9:0]  position;
   } item_type;

endpackage

[hdl/gsd_req_if.sv]
interface gsd_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [31:0] now_ms;
   logic [9:0]  position;

   modport source (output valid, output op, output now_ms, output position, input ready);
   modport sink   (input valid, input op, input now_ms, input position, output ready);
endinterface

[hdl/gsd_rsp_if.sv]
interface gsd_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] drive;
   logic [1:0] gripper_state;

   modport source (output valid, output drive, output gripper_state, input ready);
   modport sink   (input valid, input drive, input gripper_state, output ready);
endinterface

[hdl/gripper_stall_detect_fsm.sv]
// channel  dir  payload                              transaction
// req_ch   in   op[1:0] now_ms[31:0] position[9:0]   valid & ready
// rsp_ch   out  drive[1:0] gripper_state[1:0]        valid & ready
// csr_*    in   csr_index[2:0] csr_wdata[15:0]       csr_we
//
// One transaction per cycle sustained while the response side is ready; a request
// travels through an input register, then the step logic into the response
// register. The mode/reference state loop updates in the same cycle the
// step fires, so back-to-back ticks see each other's result.
// Synchronous reset restores the register defaults and the closed mode.
// A stalled response holds the pipe; one request still lands in the input register.
module gripper_stall_detect_fsm
   import gsd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   gsd_req_if.sink                req_ch,
   gsd_rsp_if.source              rsp_ch,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type   cfg;
   state_type state_ff;
   state_type state_in;
   drive_type drive_in;

   logic      in_valid_ff;
   item_type  in_item_ff;
   logic      out_valid_ff;
   drive_type out_drive_ff;
   mode_type  out_mode_ff;
   logic      advance;

   gsd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   gsd_step u_step (
      .cfg   (cfg),
      .cur   (state_ff),
      .item  (in_item_ff),
      .nxt   (state_in),
      .drive (drive_in)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.ready && req_ch.valid) begin
         in_item_ff.op       <= op_type'(req_ch.op);
         in_item_ff.now_ms   <= req_ch.now_ms;
         in_item_ff.position <= req_ch.position;
      end
      if (advance) begin
         out_drive_ff <= drive_in;
         out_mode_ff  <= state_in.mode;
      end
   end

   assign rsp_ch.valid         = out_valid_ff;
   assign rsp_ch.drive         = out_drive_ff;
   assign rsp_ch.gripper_state = out_mode_ff;

endmodule

[hdl/gsd_csr.sv]
module gsd_csr
   import gsd_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_OPEN_TARGET:   cfg_in.open_target        = csr_wdata[9:0];
            CSR_CLOSED_TARGET: cfg_in.closed_target      = csr_wdata[9:0];
            CSR_TOLERANCE:     cfg_in.position_tolerance = csr_wdata[9:0];
            CSR_ACCEL_DELAY:   cfg_in.accel_delay_ms     = csr_wdata;
            CSR_CHECK_WINDOW:  cfg_in.check_window_ms    = csr_wdata;
            CSR_MIN_PROGRESS:  cfg_in.min_progress       = csr_wdata[9:0];
            CSR_MAX_FAILURES:  cfg_in.max_failures       = csr_wdata[7:0];
            default:           cfg_in = cfg_ff;  // unmapped index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[hdl/gsd_step.sv]
module gsd_step
   import gsd_pkg::*;
(
   input  cfg_type   cfg,
   input  state_type cur,
   input  item_type  item,
   output state_type nxt,
   output drive_type drive
);

   function automatic logic [9:0] abs_diff(input logic [9:0] a, input logic [9:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   logic [31:0] elapsed;
   logic        window_over;
   logic [9:0]  moved;
   logic [7:0]  fail_inc;
   state_type   checked;
   logic        stall;
   logic        at_open;
   logic        at_closed;
   logic [31:0] start_time;

   // progress check shared by both moving modes
   always_comb begin
      elapsed     = item.now_ms - cur.ref_time;
      // a reference still in the future reads as negative
      window_over = !elapsed[31] && (elapsed[30:0] > {15'd0, cfg.check_window_ms});
      moved       = abs_diff(item.position, cur.ref_position);
      fail_inc    = (cur.fail_count == 8'hFF) ? cur.fail_count : cur.fail_count + 8'd1;
      checked     = cur;
      if (window_over) begin
         if (moved < cfg.min_progress) begin
            checked.fail_count = fail_inc;
         end else begin
            checked.ref_time     = item.now_ms;
            checked.ref_position = item.position;
            checked.fail_count   = 8'd0;
         end
      end
      stall      = checked.fail_count > cfg.max_failures;
      at_open    = abs_diff(cfg.open_target, item.position) <= cfg.position_tolerance;
      at_closed  = abs_diff(cfg.closed_target, item.position) <= cfg.position_tolerance;
      start_time = item.now_ms + {16'd0, cfg.accel_delay_ms};
   end

   always_comb begin
      nxt   = cur;
      drive = DRV_NONE;
      unique case (item.op)
         OP_TICK: begin
            unique case (cur.mode)
               MODE_OPENING: begin
                  if (at_open) begin
                     nxt.mode = MODE_OPEN;
                  end else if (stall) begin
                     nxt.mode         = MODE_CLOSING;
                     nxt.ref_time     = start_time;
                     nxt.ref_position = item.position;
                     nxt.fail_count   = 8'd0;
                  end else begin
                     nxt   = checked;
                     drive = DRV_OPEN;
                  end
               end
               MODE_CLOSING: begin
                  if (at_closed) begin
                     nxt.mode = MODE_CLOSED;
                  end else if (stall) begin
                     nxt.mode         = MODE_OPENING;
                     nxt.ref_time     = start_time;
                     nxt.ref_position = item.position;
                     nxt.fail_count   = 8'd0;
                  end else begin
                     nxt   = checked;
                     drive = DRV_CLOSE;
                  end
               end
               default: drive = DRV_STOP;  // resting
            endcase
         end
         OP_OPEN: begin
            if (cur.mode != MODE_OPEN) begin
               nxt.mode         = MODE_OPENING;
               nxt.ref_time     = start_time;
               nxt.ref_position = item.position;
               nxt.fail_count   = 8'd0;
            end
         end
         OP_CLOSE: begin
            if (cur.mode != MODE_CLOSED) begin
               nxt.mode         = MODE_CLOSING;
               nxt.ref_time     = start_time;
               nxt.ref_position = item.position;
               nxt.fail_count   = 8'd0;
            end
         end
         default: begin
            nxt.mode         = MODE_CLOSED;
            nxt.ref_time     = item.now_ms;
            nxt.ref_position = item.position;
            nxt.fail_count   = 8'd0;
         end
      endcase
   end

endmodule

[hdl/gsd_checker.sv]
`include "gripper_stall_detect_fsm_defines.svh"

module gsd_checker
   import gsd_pkg::*;
(
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_drive,
   input logic [1:0] rsp_gripper_state
);

   logic       req_fire;
   logic       rsp_stall;
   logic [3:0] rsp_payload;
   logic       drive_open;
   logic       mode_opening;
   logic       drive_coded;
   logic       mode_fits;

   assign req_fire     = req_valid && req_ready;
   assign rsp_stall    = rsp_valid && !rsp_ready;
   assign rsp_payload  = {rsp_drive, rsp_gripper_state};
   assign drive_open   = rsp_valid && (rsp_drive == DRV_OPEN);
   assign mode_opening = (rsp_gripper_state == MODE_OPENING);
   assign drive_coded  = rsp_valid && ((rsp_drive == DRV_STOP) || (rsp_drive == DRV_CLOSE));
   assign mode_fits    = (rsp_drive == DRV_STOP) ?
                         ((rsp_gripper_state == MODE_OPEN) || (rsp_gripper_state == MODE_CLOSED)) :
                         (rsp_gripper_state == MODE_CLOSING);

   `GSD_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid && $stable(rsp_payload), "response changed")

   // in an empty pipe a request reaches the response via the input and response registers
   `GSD_ASSERT_IMP(a_rsp_from_req, $rose(rsp_valid), $past(req_fire, 2), "response without a request")

   `GSD_ASSERT_IMP(a_drive_open_mode, drive_open, mode_opening, "drive open outside opening")

   `GSD_ASSERT_IMP(a_drive_stop_mode, drive_coded, mode_fits, "drive code does not match mode")

endmodule

bind gripper_stall_detect_fsm gsd_checker u_gsd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_drive         (rsp_ch.drive),
   .rsp_gripper_state (rsp_ch.gripper_state)
);

[test/tb_top.sv]
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gsd_pkg::*;

   localparam int CYCLE_LIMIT = 500000;

   typedef struct packed {
      drive_type drive;
      mode_type  mode;
   } drive_state_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   gsd_req_if req_ch ();
   gsd_rsp_if rsp_ch ();

   gripper_stall_detect_fsm dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #1 clock = ~clock;

   // predicted copy of the block's registers and state
   cfg_type     cfg_now;
   mode_type    g_mode;
   logic [31:0] g_ref_time;
   logic [9:0]  g_ref_pos;
   logic [7:0]  g_fails;

   item_type        sample_queue[$];
   drive_state_type expected_drive_q[$];

   int  mismatches     = 0;
   int  accepted_count = 0;
   int  checked_count  = 0;
   int  stall_count    = 0;
   int  arrive_count   = 0;
   int  setting_count  = 1;
   int  cycles         = 0;
   int  src_gap        = 0;
   int  snk_gap        = 0;
   bit  quiet          = 1'b0;

   // sequence generator state
   logic [31:0] gen_t;
   int          gen_pos;
   bit          gen_up;
   bit          gen_stuck;

   function automatic logic [9:0] dist10(logic [9:0] a, logic [9:0] b);
      return (a > b) ? a - b : b - a;
   endfunction

   function automatic void rearm_watch(logic [31:0] now, logic [9:0] pos, logic [15:0] delay);
      g_ref_time = now + {16'd0, delay};
      g_ref_pos  = pos;
      g_fails    = 8'd0;
   endfunction

   function automatic logic stall_seen(logic [31:0] now, logic [9:0] pos);
      logic [31:0] elapsed;
      elapsed = now - g_ref_time;
      // reference still in the future reads as negative: no check
      if (!elapsed[31] && elapsed > {16'd0, cfg_now.check_window_ms}) begin
         if (dist10(pos, g_ref_pos) < cfg_now.min_progress) begin
            if (g_fails != 8'hFF) g_fails++;
         end else begin
            rearm_watch(now, pos, 16'd0);
         end
      end
      return g_fails > cfg_now.max_failures;
   endfunction

   function automatic void begin_motion(mode_type to_mode, mode_type rest_mode,
                                        logic [31:0] now, logic [9:0] pos);
      if (g_mode != rest_mode) begin
         g_mode = to_mode;
         rearm_watch(now, pos, cfg_now.accel_delay_ms);
      end
   endfunction

   function automatic drive_state_type gripper_step(item_type it);
      drive_state_type r;
      r.drive = DRV_NONE;
      case (it.op)
         OP_TICK: begin
            if (g_mode == MODE_OPENING) begin
               if (dist10(cfg_now.open_target, it.position) <= cfg_now.position_tolerance) begin
                  g_mode = MODE_OPEN;
                  arrive_count++;
               end else if (stall_seen(it.now_ms, it.position)) begin
                  begin_motion(MODE_CLOSING, MODE_CLOSED, it.now_ms, it.position);
                  stall_count++;
               end else begin
                  r.drive = DRV_OPEN;
               end
            end else if (g_mode == MODE_CLOSING) begin
               if (dist10(cfg_now.closed_target, it.position) <= cfg_now.position_tolerance) begin
                  g_mode = MODE_CLOSED;
                  arrive_count++;
               end else if (stall_seen(it.now_ms, it.position)) begin
                  begin_motion(MODE_OPENING, MODE_OPEN, it.now_ms, it.position);
                  stall_count++;
               end else begin
                  r.drive = DRV_CLOSE;
               end
            end else begin
               r.drive = DRV_STOP;
            end
         end
         OP_OPEN:  begin_motion(MODE_OPENING, MODE_OPEN, it.now_ms, it.position);
         OP_CLOSE: begin_motion(MODE_CLOSING, MODE_CLOSED, it.now_ms, it.position);
         default: begin
            g_mode = MODE_CLOSED;
            rearm_watch(it.now_ms, it.position, 16'd0);
         end
      endcase
      r.mode = g_mode;
      return r;
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            expected_drive_q.push_back(gripper_step('{op: op_type'(req_ch.op),
                                                      now_ms: req_ch.now_ms,
                                                      position: req_ch.position}));
            accepted_count++;
         end
         if (!req_ch.valid || req_ch.ready) begin
            if (src_gap > 0) begin
               src_gap--;
               req_ch.valid <= 1'b0;
            end else if (sample_queue.size() > 0 && !quiet && $urandom_range(0, 19) == 0) begin
               src_gap = $urandom_range(0, 13);
               req_ch.valid <= 1'b0;
            end else if (sample_queue.size() > 0) begin
               item_type nxt;
               nxt = sample_queue.pop_front();
               req_ch.valid    <= 1'b1;
               req_ch.op       <= nxt.op;
               req_ch.now_ms   <= nxt.now_ms;
               req_ch.position <= nxt.position;
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
      end
   end

   // response monitor and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_drive_q.size() == 0) begin
               $error("unexpected response: drive=%0d gripper_state=%0d",
                      rsp_ch.drive, rsp_ch.gripper_state);
               mismatches++;
            end else begin
               drive_state_type want;
               want = expected_drive_q.pop_front();
               checked_count++;
               if (rsp_ch.drive !== want.drive) begin
                  $error("drive: expected %0d, actual %0d", want.drive, rsp_ch.drive);
                  mismatches++;
               end
               if (rsp_ch.gripper_state !== want.mode) begin
                  $error("gripper_state: expected %0d, actual %0d",
                         want.mode, rsp_ch.gripper_state);
                  mismatches++;
               end
            end
         end
         if (snk_gap > 0) begin
            snk_gap--;
            rsp_ch.ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 19) == 0) begin
            snk_gap = $urandom_range(0, 13);
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   task automatic push_item(op_type op, logic [31:0] now, logic [9:0] pos);
      item_type it;
      it.op       = op;
      it.now_ms   = now;
      it.position = pos;
      sample_queue.push_back(it);
   endtask

   // mostly plausible motion: commands, then ticks with advancing time and
   // a position creeping toward the target or stuck; the rest is noise
   task automatic add_motion(int n);
      int r;
      int span;
      int tgt;
      int mv;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 10) begin
            push_item(op_type'($urandom_range(0, 3)), $urandom, 10'($urandom_range(0, 1023)));
         end else if (r < 14) begin
            gen_up = 1'b1;
            push_item(OP_OPEN, gen_t, 10'(gen_pos));
         end else if (r < 18) begin
            gen_up = 1'b0;
            push_item(OP_CLOSE, gen_t, 10'(gen_pos));
         end else if (r < 20) begin
            gen_up = 1'b0;
            push_item(OP_RESET, gen_t, 10'(gen_pos));
         end else begin
            span = (int'(cfg_now.check_window_ms) + int'(cfg_now.accel_delay_ms)) / 3 + 4;
            if ($urandom_range(0, 49) == 0) gen_t = gen_t + $urandom;
            else gen_t = gen_t + $urandom_range(0, span);
            if ($urandom_range(0, 15) == 0) gen_stuck = !gen_stuck;
            tgt = gen_up ? int'(cfg_now.open_target) : int'(cfg_now.closed_target);
            mv  = gen_stuck ? $urandom_range(0, cfg_now.min_progress) : $urandom_range(1, 80);
            if ($urandom_range(0, 19) == 0) gen_pos = $urandom_range(0, 1023);
            else if (gen_pos < tgt) gen_pos = (tgt - gen_pos > mv) ? gen_pos + mv : tgt;
            else gen_pos = (gen_pos - tgt > mv) ? gen_pos - mv : tgt;
            push_item(OP_TICK, gen_t, 10'(gen_pos));
         end
      end
   endtask

   task automatic wait_idle();
      while (sample_queue.size() > 0 || req_ch.valid || expected_drive_q.size() > 0)
         @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic apply_settings(cfg_type c);
      logic [CSR_INDEX_W-1:0] idx [7];
      logic [CSR_DATA_W-1:0]  val [7];
      idx = '{CSR_OPEN_TARGET, CSR_CLOSED_TARGET, CSR_TOLERANCE, CSR_ACCEL_DELAY,
              CSR_CHECK_WINDOW, CSR_MIN_PROGRESS, CSR_MAX_FAILURES};
      val = '{16'(c.open_target), 16'(c.closed_target), 16'(c.position_tolerance),
              c.accel_delay_ms, c.check_window_ms, 16'(c.min_progress),
              16'(c.max_failures)};
      for (int k = 0; k < 7; k++) begin
         @(posedge clock);
         csr_we    <= 1'b1;
         csr_index <= idx[k];
         csr_wdata <= val[k];
      end
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_now = c;
      setting_count++;
   endtask

   function automatic cfg_type random_cfg();
      cfg_type c;
      c.open_target        = 10'($urandom_range(600, 1023));
      c.closed_target      = 10'($urandom_range(0, 400));
      c.position_tolerance = 10'($urandom_range(0, 30));
      c.accel_delay_ms     = 16'($urandom_range(0, 1000));
      c.check_window_ms    = 16'($urandom_range(0, 2000));
      c.min_progress       = 10'($urandom_range(0, 40));
      c.max_failures       = 8'($urandom_range(0, 6));
      return c;
   endfunction

   initial begin
      cfg_type settings [6];
      int      counts   [6];

      reset           = 1'b1;
      csr_we          = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_ch.valid    = 1'b0;
      req_ch.op       = '0;
      req_ch.now_ms   = '0;
      req_ch.position = '0;
      rsp_ch.ready    = 1'b0;
      cfg_now         = CFG_RESET;
      g_mode          = STATE_RESET.mode;
      g_ref_time      = STATE_RESET.ref_time;
      g_ref_pos       = STATE_RESET.ref_position;
      g_fails         = STATE_RESET.fail_count;
      gen_pos         = 0;
      gen_up          = 1'b0;
      gen_stuck       = 1'b0;

      // lowest values, highest values, no-stall saturation, stall-prone, random
      settings[0] = '{open_target: 10'd0, closed_target: 10'd0, position_tolerance: 10'd0,
                      accel_delay_ms: 16'd0, check_window_ms: 16'd0, min_progress: 10'd0,
                      max_failures: 8'd0};
      settings[1] = '{open_target: 10'd1023, closed_target: 10'd1023,
                      position_tolerance: 10'd1023, accel_delay_ms: 16'hFFFF,
                      check_window_ms: 16'hFFFF, min_progress: 10'd1023, max_failures: 8'd254};
      settings[2] = '{open_target: 10'd1023, closed_target: 10'd0, position_tolerance: 10'd5,
                      accel_delay_ms: 16'd100, check_window_ms: 16'd300, min_progress: 10'd10,
                      max_failures: 8'd255};
      settings[3] = '{open_target: 10'd900, closed_target: 10'd100, position_tolerance: 10'd3,
                      accel_delay_ms: 16'd50, check_window_ms: 16'd200, min_progress: 10'd8,
                      max_failures: 8'd1};
      settings[4] = random_cfg();
      settings[5] = random_cfg();
      counts = '{240, 150, 240, 240, 240, 340};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed pass at reset register values
      push_item(OP_TICK,  32'd0,    10'd0);
      push_item(OP_CLOSE, 32'd5,    10'd0);     // close while closed
      push_item(OP_OPEN,  32'd10,   10'd0);
      push_item(OP_OPEN,  32'd20,   10'd3);     // re-arm while opening
      push_item(OP_TICK,  32'd100,  10'd50);    // reference still ahead
      push_item(OP_TICK,  32'd300,  10'd1013);  // edge of tolerance
      push_item(OP_OPEN,  32'd310,  10'd1013);  // open while open
      push_item(OP_TICK,  32'd320,  10'd1023);
      push_item(OP_CLOSE, 32'd330,  10'd1023);
      push_item(OP_TICK,  32'd1100, 10'd1000);  // enough progress, re-arm
      push_item(OP_TICK,  32'd1601, 10'd998);
      push_item(OP_TICK,  32'd1602, 10'd997);
      push_item(OP_TICK,  32'd1603, 10'd997);
      push_item(OP_TICK,  32'd1604, 10'd996);   // stall, reverse to opening
      push_item(OP_TICK,  32'd1700, 10'd996);
      push_item(OP_CLOSE, 32'd1710, 10'd900);
      push_item(OP_TICK,  32'd1720, 10'd11);
      push_item(OP_TICK,  32'd1730, 10'd10);
      push_item(OP_RESET, 32'hFFFF_FFFF, 10'd1023);
      push_item(OP_OPEN,  32'hFFFF_FF80, 10'd1023);  // reference wraps past zero
      push_item(OP_TICK,  32'h0000_0300, 10'd500);
      push_item(OP_TICK,  32'h7FFF_FFFF, 10'd0);
      push_item(OP_TICK,  32'hFFFF_FFFF, 10'd500);   // elapsed reads negative
      push_item(OP_RESET, 32'd0,    10'd0);

      gen_t = $urandom;
      add_motion(250);
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         apply_settings(settings[p]);
         quiet = (p == 5);
         gen_t = (p == 4) ? 32'hFFFF_F000 : $urandom;
         @(negedge clock);
         add_motion(counts[p]);
         wait_idle();
      end

      $display("Covered %0d transactions, %0d responses checked, over %0d register settings.",
               accepted_count, checked_count, setting_count);
      $display("Predicted %0d stall reversals and %0d target arrivals.",
               stall_count, arrive_count);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+hdl
hdl/gsd_pkg.sv
hdl/gsd_req_if.sv
hdl/gsd_rsp_if.sv
hdl/gsd_csr.sv
hdl/gsd_step.sv
hdl/gripper_stall_detect_fsm.sv
hdl/gsd_checker.sv
test/tb_top.sv
